/* rtl/spi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spi_pkg
// Shared types, codes and widths of the stopping-power interpolator.
// ----------------------------------------------------------------------------
package spi_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = 8;
   localparam int CNT_W       = 9;
   localparam logic [CNT_W-1:0] DEPTH_N = CNT_W'(TABLE_DEPTH);

   // arithmetic unit widths
   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 36;
   localparam int MUL_P_W = 100;
   localparam int DIV_N_W = 64;
   localparam int DIV_D_W = 33;
   localparam int DIV_C_W = 7;
   localparam logic [DIV_C_W-1:0] DIV_STEPS = DIV_C_W'(DIV_N_W);

   // one in q16.16, one bit wider
   localparam logic [16:0] ONE_Q = 17'h10000;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_POINTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERP       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ENERGY   = 2'd2;

   localparam logic ACTION_WRITE = 1'b0;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_BELOW = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_WRITE = 2'd3
   } status_type;

   typedef struct packed {
      logic        action;
      logic [7:0]  entry_index;
      logic [31:0] entry_energy;
      logic [31:0] entry_electronic;
      logic [31:0] entry_nuclear;
      logic [31:0] query_energy;
      logic [31:0] query_distance;
   } req_type;

   typedef struct packed {
      logic [31:0] energy_loss;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] energy;
      logic [31:0] electronic;
      logic [31:0] nuclear;
   } entry_type;

   // datapath operations
   typedef enum logic [2:0] {
      OP_NONE       = 3'd0,
      OP_LOAD       = 3'd1,
      OP_SCAN_START = 3'd2,
      OP_SCAN       = 3'd3,
      OP_FETCH      = 3'd4,
      OP_CAPTURE    = 3'd5,
      OP_START      = 3'd6,
      OP_REPORT     = 3'd7
   } op_type;

   // arithmetic steps of the interpolation
   typedef enum logic [3:0] {
      STEP_T    = 4'd0,
      STEP_LIN  = 4'd1,
      STEP_D0   = 4'd2,
      STEP_D1   = 4'd3,
      STEP_HH   = 4'd4,
      STEP_G    = 4'd5,
      STEP_C    = 4'd6,
      STEP_U    = 4'd7,
      STEP_V    = 4'd8,
      STEP_SPL  = 4'd9,
      STEP_LOSS = 4'd10
   } step_type;

   typedef struct packed {
      op_type     op;
      step_type   step;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic is_write;
      logic below;
      logic few_points;
      logic spline;
      logic found;
      logic scan_end;
      logic third_past_end;
      logic bad_third;
      logic unit_done;
   } stat_type;

endpackage
`default_nettype wire

/* rtl/stopping_power_interpolator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stopping_power_interpolator_core
// Stopping-power table with linear or three-point spline interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: a table write (action 0) or an energy-loss
//   query (action 1). rsp_* returns exactly one result per transaction.
//   csr_* writes table_points, interp_method and min_energy; csr_ready is
//   always high. Writes are made only while the block is idle: the user must
//   keep to this, as the block itself does not enforce it. One transaction is
//   in work at a time. A query scans the table one entry a cycle through the
//   single read port, then runs its arithmetic steps one after another, each
//   started from an issue state: the divider takes one quotient bit a cycle
//   and the multiplier one multiplier bit a cycle; spline mode runs more steps
//   than linear mode. The result sits in an output register; the next request
//   is taken while it waits, and the block stalls only when a second result
//   is ready before the first one is taken. Reset restores the configuration
//   defaults and clears the controller state, the result valid flag and the
//   unit busy flags; table contents are undefined until written.
// ----------------------------------------------------------------------------
module stopping_power_interpolator_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire spi_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output spi_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [spi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]                    csr_data
);
   import spi_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   // control
   spi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // storage and arithmetic
   spi_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* rtl/spi_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spi_mul
// Shift-and-add multiplier, one multiplier bit per cycle, stops early
// once the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module spi_mul (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [spi_pkg::MUL_A_W-1:0]  a,
   input  wire logic [spi_pkg::MUL_B_W-1:0]  b,
   output logic                              done,
   output logic [spi_pkg::MUL_P_W-1:0]       product
);
   import spi_pkg::*;

   logic                busy_ff, busy_in;
   logic [MUL_P_W-1:0]  acc_ff, acc_in;
   logic [MUL_P_W-1:0]  a_ff, a_in;
   logic [MUL_B_W-1:0]  b_ff, b_in;

   // next state of the accumulation
   always_comb begin
      busy_in = busy_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         a_in    = {{(MUL_P_W-MUL_A_W){1'b0}}, a};
         b_in    = b;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_ff[0]) acc_in = acc_ff + a_ff;
            a_in = {a_ff[MUL_P_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[MUL_B_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = busy_ff && (b_ff == '0);
   assign product = acc_ff;

endmodule
`default_nettype wire

/* rtl/spi_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spi_div
// Restoring divider, one quotient bit per cycle over the whole numerator.
// ----------------------------------------------------------------------------
module spi_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [spi_pkg::DIV_N_W-1:0]  num,
   input  wire logic [spi_pkg::DIV_D_W-1:0]  den,
   output logic                              done,
   output logic [spi_pkg::DIV_N_W-1:0]       quot
);
   import spi_pkg::*;

   logic                busy_ff, busy_in;
   logic [DIV_C_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_N_W-1:0]  num_ff, num_in;
   logic [DIV_D_W-1:0]  den_ff, den_in;
   logic [DIV_D_W-1:0]  rem_ff, rem_in;
   logic [DIV_D_W:0]    rem_sh;
   logic [DIV_D_W:0]    rem_sub;

   // one compare and subtract a cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff, num_ff[DIV_N_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == DIV_STEPS) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sub[DIV_D_W-1:0];
               num_in = {num_ff[DIV_N_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DIV_D_W-1:0];
               num_in = {num_ff[DIV_N_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = busy_ff && (cnt_ff == DIV_STEPS);
   assign quot = num_ff;

endmodule
`default_nettype wire

/* rtl/spi_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spi_datapath
// Table memory, configuration registers, interval scan, operand registers
// and the shared multiplier and divider of the interpolator.
// ----------------------------------------------------------------------------
module spi_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire spi_pkg::req_type               req_data,
   input  wire logic                           csr_valid,
   input  wire logic [spi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]                    csr_data,
   input  wire spi_pkg::cmd_type               cmd,
   output spi_pkg::stat_type                   stat,
   output spi_pkg::rsp_type                    rsp_data
);
   import spi_pkg::*;

   // configuration
   logic [CNT_W-1:0] points_ff;
   logic             method_ff;
   logic [31:0]      min_e_ff;
   logic [CNT_W-1:0] n_eff;

   // table memory
   entry_type        mem [TABLE_DEPTH];
   entry_type        rd_ff;
   logic [ADDR_W-1:0] raddr;
   logic [32:0]      rd_y;

   // query and scan registers
   logic             is_write_ff;
   logic [31:0]      e_q_ff, d_q_ff;
   logic [CNT_W-1:0] addr_ff;
   logic             chk_vld_ff;
   logic [ADDR_W-1:0] chk_idx_ff, i_ff;
   logic [31:0]      prev_e_ff, x0_ff, x1_ff, x2_ff;
   logic [32:0]      prev_y_ff, y0_ff, y1_ff, y2_ff;
   logic             found;

   // step results
   logic [15:0]      t_ff, u_ff;
   logic [16:0]      v_ff;
   logic [49:0]      d0_ff, d1_ff;
   logic [63:0]      hh_ff;
   logic [31:0]      g_ff, loss_ff;
   logic [61:0]      c_mag_ff;
   logic             c_neg_ff;
   logic [63:0]      s_ff;
   step_type         cur_step_ff;

   // derived operands
   logic [31:0]      h0, h1, e_off;
   logic             dy0_neg, dy1_neg, dd_neg;
   logic [32:0]      dy0_mag, dy1_mag;
   logic [32:0]      den_g;
   logic [50:0]      d0_s, d1_s, dd, dd_mag;
   logic [35:0]      dist10;
   logic [32:0]      lin;
   logic [61:0]      spl;
   logic [63:0]      lin_s, spl_s;

   // unit interface
   logic                mul_start, mul_done, div_start, div_done;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [MUL_P_W-1:0]  mul_p;
   logic [DIV_N_W-1:0]  div_num, div_q;
   logic [DIV_D_W-1:0]  div_den;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= 9'd2;
         method_ff <= 1'b0;
         min_e_ff  <= 32'd655;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TABLE_POINTS: points_ff <= csr_data[CNT_W-1:0];
            CSR_INTERP:       method_ff <= csr_data[0];
            CSR_MIN_ENERGY:   min_e_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign n_eff = (points_ff > DEPTH_N) ? DEPTH_N : points_ff;

   // table write on a write transaction, registered read
   assign raddr = (cmd.op == OP_FETCH) ? (i_ff + 1'b1) : addr_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && req_data.action == ACTION_WRITE) begin
         mem[req_data.entry_index] <= '{energy:     req_data.entry_energy,
                                        electronic: req_data.entry_electronic,
                                        nuclear:    req_data.entry_nuclear};
      end
      rd_ff <= mem[raddr];
   end

   assign rd_y = {1'b0, rd_ff.electronic} + {1'b0, rd_ff.nuclear};

   // bracketing test on the entry just read
   assign found = chk_vld_ff && (chk_idx_ff != '0) && (prev_e_ff <= e_q_ff)
                  && (e_q_ff < rd_ff.energy);

   // query capture and interval scan
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff <= 1'b0;
      end else if (cmd.op == OP_SCAN && addr_ff < n_eff) begin
         chk_vld_ff <= 1'b1;
      end else begin
         chk_vld_ff <= 1'b0;
      end
      if (cmd.op == OP_LOAD) begin
         is_write_ff <= (req_data.action == ACTION_WRITE);
         e_q_ff      <= req_data.query_energy;
         d_q_ff      <= req_data.query_distance;
      end
      if (cmd.op == OP_SCAN_START) addr_ff <= '0;
      if (cmd.op == OP_SCAN) begin
         if (addr_ff < n_eff) begin
            addr_ff    <= addr_ff + 1'b1;
            chk_idx_ff <= addr_ff[ADDR_W-1:0];
         end
         if (chk_vld_ff) begin
            prev_e_ff <= rd_ff.energy;
            prev_y_ff <= rd_y;
            if (found) begin
               x0_ff <= prev_e_ff;
               y0_ff <= prev_y_ff;
               x1_ff <= rd_ff.energy;
               y1_ff <= rd_y;
               i_ff  <= chk_idx_ff;
            end
         end
      end
      if (cmd.op == OP_CAPTURE) begin
         x2_ff <= rd_ff.energy;
         y2_ff <= rd_y;
      end
   end

   // operand differences
   always_comb begin
      h0      = x1_ff - x0_ff;
      h1      = x2_ff - x1_ff;
      e_off   = e_q_ff - x0_ff;
      dy0_neg = (y1_ff < y0_ff);
      dy0_mag = dy0_neg ? (y0_ff - y1_ff) : (y1_ff - y0_ff);
      dy1_neg = (y2_ff < y1_ff);
      dy1_mag = dy1_neg ? (y1_ff - y2_ff) : (y2_ff - y1_ff);
      den_g   = {1'b0, h0} + {1'b0, h1};
      d0_s    = dy0_neg ? (51'd0 - {1'b0, d0_ff}) : {1'b0, d0_ff};
      d1_s    = dy1_neg ? (51'd0 - {1'b0, d1_ff}) : {1'b0, d1_ff};
      dd      = d0_s - d1_s;
      dd_neg  = dd[50];
      dd_mag  = dd_neg ? (51'd0 - dd) : dd;
      dist10  = {1'b0, d_q_ff, 3'b000} + {3'b000, d_q_ff, 1'b0};
      lin     = mul_p[48:16];
      spl     = mul_p[78:17];
      lin_s   = dy0_neg ? (64'd0 - {31'd0, lin}) : {31'd0, lin};
      spl_s   = c_neg_ff ? (64'd0 - {2'd0, spl}) : {2'd0, spl};
   end

   // operand select for the step being started
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      div_num = '0;
      div_den = {1'b0, h0};
      case (cmd.step)
         STEP_T:    div_num = {16'd0, e_off, 16'd0};
         STEP_D0:   div_num = {15'd0, dy0_mag, 16'd0};
         STEP_D1:   begin
            div_num = {15'd0, dy1_mag, 16'd0};
            div_den = {1'b0, h1};
         end
         STEP_G:    begin
            div_num = hh_ff;
            div_den = den_g;
         end
         STEP_LIN:  begin
            mul_a = {31'd0, dy0_mag};
            mul_b = {20'd0, t_ff};
         end
         STEP_HH:   begin
            mul_a = {32'd0, h0};
            mul_b = {4'd0, h0};
         end
         STEP_C:    begin
            mul_a = {13'd0, dd_mag};
            mul_b = {4'd0, g_ff};
         end
         STEP_U:    begin
            mul_a = {48'd0, t_ff};
            mul_b = {19'd0, ONE_Q - {1'b0, t_ff}};
         end
         STEP_V:    begin
            mul_a = {48'd0, u_ff};
            mul_b = {19'd0, ONE_Q + {1'b0, t_ff}};
         end
         STEP_SPL:  begin
            mul_a = {2'd0, c_mag_ff};
            mul_b = {19'd0, v_ff};
         end
         STEP_LOSS: begin
            mul_a = s_ff[63] ? '0 : s_ff;
            mul_b = dist10;
         end
         default: ;
      endcase
      div_start = 1'b0;
      mul_start = 1'b0;
      if (cmd.op == OP_START) begin
         case (cmd.step)
            STEP_T, STEP_D0, STEP_D1, STEP_G: div_start = 1'b1;
            default:                          mul_start = 1'b1;
         endcase
      end
   end

   spi_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   spi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   // step result write-back
   always_ff @(posedge clock) begin
      if (cmd.op == OP_START) cur_step_ff <= cmd.step;
      if (div_done) begin
         case (cur_step_ff)
            STEP_T:  t_ff  <= div_q[15:0];
            STEP_D0: d0_ff <= div_q[49:0];
            STEP_D1: d1_ff <= div_q[49:0];
            STEP_G:  g_ff  <= div_q[31:0];
            default: ;
         endcase
      end
      if (mul_done) begin
         case (cur_step_ff)
            STEP_LIN:  s_ff  <= {31'd0, y0_ff} + lin_s;
            STEP_HH:   hh_ff <= mul_p[63:0];
            STEP_C:    begin
               c_mag_ff <= (mul_p[99:78] != '0) ? {62{1'b1}} : mul_p[77:16];
               c_neg_ff <= dd_neg;
            end
            STEP_U:    u_ff <= mul_p[31:16];
            STEP_V:    v_ff <= mul_p[32:16];
            STEP_SPL:  s_ff <= s_ff + spl_s;
            STEP_LOSS: loss_ff <= (mul_p[99:48] != '0) ? 32'hFFFF_FFFF : mul_p[47:16];
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.op == OP_REPORT) begin
         rsp_data.energy_loss <= (cmd.status == STATUS_OK) ? loss_ff : 32'd0;
         rsp_data.status      <= cmd.status;
      end
   end

   // status to the controller
   always_comb begin
      stat.is_write       = is_write_ff;
      stat.below          = (e_q_ff < min_e_ff);
      stat.few_points     = (n_eff < 9'd2);
      stat.spline         = method_ff;
      stat.found          = found;
      stat.scan_end       = chk_vld_ff && !found
                            && ({1'b0, chk_idx_ff} == (n_eff - 1'b1));
      stat.third_past_end = (({1'b0, i_ff} + 1'b1) >= n_eff);
      stat.bad_third      = (rd_ff.energy <= x1_ff);
      stat.unit_done      = mul_done || div_done;
   end

endmodule
`default_nettype wire

/* rtl/spi_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spi_ctrl
// Controller: accepts transactions, runs the scan and the arithmetic steps
// and hands results to the output register.
// ----------------------------------------------------------------------------
module spi_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output spi_pkg::cmd_type        cmd,
   input  wire spi_pkg::stat_type  stat
);
   import spi_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_DECODE     = 8'b0000_0010,
      ST_SCAN       = 8'b0000_0100,
      ST_FETCH      = 8'b0000_1000,
      ST_FETCH_WAIT = 8'b0001_0000,
      ST_ISSUE      = 8'b0010_0000,
      ST_WAIT       = 8'b0100_0000,
      ST_REPORT     = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   step_type   step_ff, step_in;
   status_type rpt_ff, rpt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // order of the arithmetic steps
   function automatic step_type next_step(input step_type s, input logic spline);
      step_type r;
      case (s)
         STEP_T:   r = STEP_LIN;
         STEP_LIN: r = spline ? STEP_D0 : STEP_LOSS;
         STEP_D0:  r = STEP_D1;
         STEP_D1:  r = STEP_HH;
         STEP_HH:  r = STEP_G;
         STEP_G:   r = STEP_C;
         STEP_C:   r = STEP_U;
         STEP_U:   r = STEP_V;
         STEP_V:   r = STEP_SPL;
         default:  r = STEP_LOSS;
      endcase
      return r;
   endfunction

   // sequencing
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rpt_in       = rpt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.op       = OP_NONE;
      cmd.step     = step_ff;
      cmd.status   = rpt_ff;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_write) begin
               rpt_in   = STATUS_WRITE;
               state_in = ST_REPORT;
            end else if (stat.below) begin
               rpt_in   = STATUS_BELOW;
               state_in = ST_REPORT;
            end else if (stat.few_points) begin
               rpt_in   = STATUS_RANGE;
               state_in = ST_REPORT;
            end else begin
               cmd.op   = OP_SCAN_START;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.op = OP_SCAN;
            if (stat.found) begin
               if (stat.spline) begin
                  state_in = ST_FETCH;
               end else begin
                  step_in  = STEP_T;
                  state_in = ST_ISSUE;
               end
            end else if (stat.scan_end) begin
               rpt_in   = STATUS_RANGE;
               state_in = ST_REPORT;
            end
         end
         ST_FETCH: begin
            if (stat.third_past_end) begin
               rpt_in   = STATUS_RANGE;
               state_in = ST_REPORT;
            end else begin
               cmd.op   = OP_FETCH;
               state_in = ST_FETCH_WAIT;
            end
         end
         ST_FETCH_WAIT: begin
            if (stat.bad_third) begin
               rpt_in   = STATUS_RANGE;
               state_in = ST_REPORT;
            end else begin
               cmd.op   = OP_CAPTURE;
               step_in  = STEP_T;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.op   = OP_START;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (stat.unit_done) begin
               if (step_ff == STEP_LOSS) begin
                  rpt_in   = STATUS_OK;
                  state_in = ST_REPORT;
               end else begin
                  step_in  = next_step(step_ff, stat.spline);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_REPORT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_REPORT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff <= step_in;
      rpt_ff  <= rpt_in;
   end

   assign rsp_valid = rsp_valid_ff;

   // a new result never overwrites one still waiting
   a_report_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_REPORT |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while stalled");

   // a bracketing hit only follows a scan cycle
   a_found_scan: assert property (@(posedge clock) disable iff (reset)
      stat.found |-> $past(cmd.op == OP_SCAN))
      else $error("interval hit outside scan");

   // arithmetic units finish only while a step is awaited
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      stat.unit_done |-> state_ff == ST_WAIT)
      else $error("unexpected unit completion");

endmodule
`default_nettype wire
